// ===== design/scan_word_deframer_normalizer_core_defines.svh =====
// Assertion macros for the scan word deframer and normalizer.
// Used by the port checker; the including module must provide clk_i and rst_ni.
`ifndef SCAN_WORD_DEFRAMER_NORMALIZER_CORE_DEFINES_SVH
`define SCAN_WORD_DEFRAMER_NORMALIZER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWDN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scan word deframer check failed");

// The consequent must hold in the cycle after the antecedent.
`define SWDN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scan word deframer check failed");

`endif

// ===== design/swdn_pkg.sv =====
// Shared constants, types and helper functions for the scan word deframer.
// No dependencies; every design file but the macros header imports this package.
`default_nettype none

package swdn_pkg;

  // Limits of the image geometry.
  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;

  // Field widths.
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned CNT_W      = 13;
  localparam int unsigned PEAK_W     = 13;
  localparam int unsigned IDX_W      = 24;
  localparam int unsigned GRAY_W     = 8;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned RTW_W      = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned PHASE_W    = 3;

  // Samples at or above this level never move the peak.
  localparam logic [WORD_W-1:0] ADC_LIMIT = 16'd8192;

  // Marker words that open a six word record.
  localparam logic [WORD_W-1:0] MARK_LINE  = 16'hFEFA;
  localparam logic [WORD_W-1:0] MARK_FRAME = 16'hFEFB;
  localparam logic [WORD_W-1:0] MARK_BEAT  = 16'hFEFC;

  localparam int unsigned RECORD_WORDS = 6;
  localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(RECORD_WORDS - 1);

  // Saturation points of the counters.
  localparam logic [CNT_W-1:0] ROW_CAP = 13'h1FFF;
  localparam logic [CNT_W-1:0] COL_CAP = 13'h1FFF;

  // Register reset values and clamp limits.
  localparam logic [CFG_DATA_W-1:0] LINE_WIDTH_RST   = 13'd1024;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 13'd1024;
  localparam logic [CFG_DATA_W-1:0] LINE_WIDTH_MAX   = CFG_DATA_W'(MAX_WIDTH);
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_MAX = CFG_DATA_W'(MAX_HEIGHT);

  // Gray scaling: 8 quotient bits, full scale 255.
  localparam int unsigned DIV_STEPS = GRAY_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);
  localparam logic [GRAY_W-1:0] GRAY_MAX = 8'd255;

  // Command queue between front and back.
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QUEUE_DEPTH = 1 << QPTR_W;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } reg_idx_e;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_PIXEL = 3'd0,
    KIND_LINE  = 3'd1,
    KIND_FRAME = 3'd2,
    KIND_BEAT  = 3'd3,
    KIND_DROP  = 3'd4
  } kind_e;

  // One classified word handed from the front to the back.
  typedef struct packed {
    kind_e              kind;
    logic [WORD_W-1:0]  word;      // sample, or last status word of a report
    logic [CNT_W-1:0]   row;
    logic [CNT_W-1:0]   column;
    logic               wrapped;
    logic [WORD_W-1:0]  stat0;
    logic [WORD_W-1:0]  stat1;
    logic [WORD_W-1:0]  stat2;
    logic [RTW_W-1:0]   stat3;
    logic [PEAK_W-1:0]  peak;
    logic [WORD_W-1:0]  trough;
  } cmd_t;

  // Clamp a register write into 1..hi.
  function automatic logic [CFG_DATA_W-1:0] clamp_reg(input logic [CFG_DATA_W-1:0] v,
                                                      input logic [CFG_DATA_W-1:0] hi);
    logic [CFG_DATA_W-1:0] r;
    if (v == '0) begin
      r = CFG_DATA_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Advance the row, saturating at the cap.
  function automatic logic [CNT_W-1:0] row_advance(input logic [CNT_W-1:0] r);
    logic [CNT_W-1:0] n;
    n = (r >= ROW_CAP) ? ROW_CAP : r + CNT_W'(1);
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== design/swdn_if.sv =====
// Channel interfaces of the scan word deframer: capture words in, results out.
// Depends on swdn_pkg for field widths.
`default_nettype none

interface swdn_word_if;
  import swdn_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] capture_word;

  modport source (output valid, output capture_word, input ready);
  modport sink   (input valid, input capture_word, output ready);
endinterface

interface swdn_result_if;
  import swdn_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] result_kind;
  logic [IDX_W-1:0]  pixel_index;
  logic [GRAY_W-1:0] gray_value;
  logic              row_wrapped;
  logic [WORD_W-1:0] pulse_seconds;
  logic [WORD_W-1:0] pulse_micros;
  logic [WORD_W-1:0] scan_mode;
  logic [RTW_W-1:0]  row_time_whole;
  logic [WORD_W-1:0] row_time_micros;
  logic [PEAK_W-1:0] peak_level;
  logic [WORD_W-1:0] floor_level;

  modport source (output valid, output result_kind, output pixel_index, output gray_value,
                  output row_wrapped, output pulse_seconds, output pulse_micros,
                  output scan_mode, output row_time_whole, output row_time_micros,
                  output peak_level, output floor_level, input ready);
  modport sink   (input valid, input result_kind, input pixel_index, input gray_value,
                  input row_wrapped, input pulse_seconds, input pulse_micros,
                  input scan_mode, input row_time_whole, input row_time_micros,
                  input peak_level, input floor_level, output ready);
endinterface

`default_nettype wire

// ===== design/swdn_front.sv =====
// Front end: accepts capture words, tracks records, counters, peak and floor.
// Depends on swdn_pkg and swdn_word_if; pushes commands into swdn_queue.
`default_nettype none

module swdn_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  swdn_word_if.sink                  word_i,
  input  logic [swdn_pkg::CNT_W-1:0] line_width_i,
  input  logic [swdn_pkg::CNT_W-1:0] frame_height_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output swdn_pkg::cmd_t             cmd_o
);
  import swdn_pkg::*;

  logic [PHASE_W-1:0] phase_q, phase_d;
  kind_e              type_q, type_d;
  logic [CNT_W-1:0]   column_q, column_d;
  logic [CNT_W-1:0]   row_q, row_d;
  logic [PEAK_W-1:0]  peak_q, peak_d;
  logic [WORD_W-1:0]  trough_q, trough_d;
  logic [WORD_W-1:0]  held_q [4];
  logic               held_we;
  logic [1:0]         held_idx;

  logic               accept;
  logic [WORD_W-1:0]  w;
  logic [PEAK_W-1:0]  peak_pick, peak_s;
  logic [WORD_W-1:0]  trough_s;
  logic               wrap_s;
  logic [CNT_W-1:0]   row_s;
  logic               col_fits;

  // A word is taken whenever the queue has room.
  assign word_i.ready = !q_full_i;
  assign accept       = word_i.valid && !q_full_i;
  assign w            = word_i.capture_word;
  assign held_idx     = phase_q[1:0] - 2'd1;

  // Sample path: peak, floor, row wrap and line fit.
  assign peak_pick = ((w > {3'b000, peak_q}) && (w < ADC_LIMIT)) ? w[PEAK_W-1:0] : peak_q;
  assign peak_s    = (peak_pick == '0) ? PEAK_W'(1) : peak_pick;
  assign trough_s  = (w < trough_q) ? w : trough_q;
  assign wrap_s    = (row_q >= frame_height_i);
  assign row_s     = wrap_s ? '0 : row_q;
  assign col_fits  = (column_q < line_width_i);

  // Classify the word and work out the next state.
  always_comb begin
    phase_d    = phase_q;
    type_d     = type_q;
    column_d   = column_q;
    row_d      = row_q;
    peak_d     = peak_q;
    trough_d   = trough_q;
    held_we    = 1'b0;
    push_o     = 1'b0;
    cmd_o      = '0;
    cmd_o.peak   = peak_q;
    cmd_o.trough = trough_q;
    if (accept) begin
      if (phase_q != '0) begin
        if (type_q == KIND_BEAT) begin
          // Heartbeat payload words are skipped.
          phase_d = (phase_q >= LAST_PHASE) ? '0 : phase_q + PHASE_W'(1);
        end else if (phase_q < LAST_PHASE) begin
          held_we = 1'b1;
          phase_d = phase_q + PHASE_W'(1);
        end else begin
          // Last status word closes the record and moves the counters.
          phase_d      = '0;
          column_d     = '0;
          row_d        = (type_q == KIND_FRAME) ? '0 : row_advance(row_q);
          push_o       = 1'b1;
          cmd_o.kind   = type_q;
          cmd_o.word   = w;
          cmd_o.stat0  = held_q[0];
          cmd_o.stat1  = held_q[1];
          cmd_o.stat2  = held_q[2];
          cmd_o.stat3  = held_q[3][WORD_W-1:WORD_W-RTW_W];
        end
      end else if (w == MARK_LINE) begin
        phase_d = PHASE_W'(1);
        type_d  = KIND_LINE;
      end else if (w == MARK_FRAME) begin
        phase_d = PHASE_W'(1);
        type_d  = KIND_FRAME;
      end else if (w == MARK_BEAT) begin
        phase_d    = PHASE_W'(1);
        type_d     = KIND_BEAT;
        push_o     = 1'b1;
        cmd_o.kind = KIND_BEAT;
      end else begin
        peak_d        = peak_s;
        trough_d      = trough_s;
        push_o        = 1'b1;
        cmd_o.peak    = peak_s;
        cmd_o.trough  = trough_s;
        cmd_o.wrapped = wrap_s;
        if (col_fits) begin
          cmd_o.kind   = KIND_PIXEL;
          cmd_o.word   = w;
          cmd_o.row    = row_s;
          cmd_o.column = column_q;
          row_d        = row_s;
          column_d     = (column_q >= COL_CAP) ? COL_CAP : column_q + CNT_W'(1);
        end else begin
          // Sample past the end of the line: drop it and start a new line.
          cmd_o.kind = KIND_DROP;
          row_d      = row_advance(row_s);
          column_d   = CNT_W'(1);
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      type_q   <= KIND_PIXEL;
      column_q <= '0;
      row_q    <= '0;
      peak_q   <= '0;
      trough_q <= '1;
    end else begin
      phase_q  <= phase_d;
      type_q   <= type_d;
      column_q <= column_d;
      row_q    <= row_d;
      peak_q   <= peak_d;
      trough_q <= trough_d;
    end
  end

  // Held status words are always written before they are read.
  always_ff @(posedge clk_i) begin
    if (held_we) begin
      held_q[held_idx] <= w;
    end
  end

endmodule

`default_nettype wire

// ===== design/swdn_queue.sv =====
// Short command queue between the front and the back of the deframer.
// Depends on swdn_pkg for the command type and the depth.
`default_nettype none

module swdn_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  swdn_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output swdn_pkg::cmd_t head_o
);
  import swdn_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q;
  logic [QPTR_W-1:0] rd_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QPTR_W+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QPTR_W+1)'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/swdn_back.sv =====
// Back end: computes pixel address and gray level, holds the result word.
// Depends on swdn_pkg and swdn_result_if; pops commands from swdn_queue.
`default_nettype none

module swdn_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       head_valid_i,
  input  swdn_pkg::cmd_t             head_i,
  output logic                       pop_o,
  input  logic [swdn_pkg::CNT_W-1:0] line_width_i,
  swdn_result_if.source              result_o
);
  import swdn_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    kind_e             kind;
    logic [IDX_W-1:0]  index;
    logic [GRAY_W-1:0] gray;
    logic              wrapped;
    logic [WORD_W-1:0] seconds;
    logic [WORD_W-1:0] micros;
    logic [WORD_W-1:0] mode;
    logic [RTW_W-1:0]  rt_whole;
    logic [WORD_W-1:0] rt_micros;
    logic [PEAK_W-1:0] peak;
    logic [WORD_W-1:0] trough;
  } res_t;

  localparam int unsigned NUM_W  = PEAK_W + GRAY_W;
  localparam int unsigned PROD_W = 2 * CNT_W;

  state_e              state_q;
  cmd_t                cur_q;
  logic [PROD_W-1:0]   prod_q;
  logic [PEAK_W-1:0]   rem_q;
  logic [GRAY_W-1:0]   nlo_q;
  logic [STEP_W-1:0]   step_q;
  logic                sat_q;
  logic                out_valid_q;
  res_t                res_q;

  logic                out_free;
  logic                load_out;
  logic [PEAK_W-1:0]   w13;
  logic                head_sat;
  logic [NUM_W-1:0]    numer;
  logic [PROD_W-1:0]   prod_d;
  logic [PEAK_W:0]     rem_ext;
  logic [PEAK_W:0]     rem_sub;
  logic                ge;
  logic [PEAK_W-1:0]   rem_nx;
  logic [PROD_W-1:0]   idx_sum;
  logic                is_pixel;
  logic                is_report;
  res_t                res_d;

  assign out_free = !out_valid_q || result_o.ready;
  assign load_out = (state_q == ST_OUT) && out_free;
  assign pop_o    = (state_q == ST_IDLE) && head_valid_i;

  // Setup: a sample at or above the peak saturates; else word*255 has an 8 bit quotient.
  assign w13      = head_i.word[PEAK_W-1:0];
  assign head_sat = (head_i.word >= {3'b000, head_i.peak});
  assign numer    = {w13, {GRAY_W{1'b0}}} - {{GRAY_W{1'b0}}, w13};
  assign prod_d   = PROD_W'(head_i.row) * PROD_W'(line_width_i);

  // One restoring division step per cycle.
  assign rem_ext = {rem_q, nlo_q[GRAY_W-1]};
  assign rem_sub = rem_ext - {1'b0, cur_q.peak};
  assign ge      = (rem_ext >= {1'b0, cur_q.peak});
  assign rem_nx  = ge ? rem_sub[PEAK_W-1:0] : rem_ext[PEAK_W-1:0];

  // Result assembly; fields that do not apply to a kind stay zero.
  assign idx_sum   = prod_q + PROD_W'(cur_q.column);
  assign is_pixel  = (cur_q.kind == KIND_PIXEL);
  assign is_report = (cur_q.kind == KIND_LINE) || (cur_q.kind == KIND_FRAME);

  always_comb begin
    res_d           = '0;
    res_d.kind      = cur_q.kind;
    res_d.wrapped   = cur_q.wrapped;
    res_d.peak      = cur_q.peak;
    res_d.trough    = cur_q.trough;
    res_d.seconds   = cur_q.stat0;
    res_d.micros    = cur_q.stat1;
    res_d.mode      = cur_q.stat2;
    res_d.rt_whole  = cur_q.stat3;
    if (is_pixel) begin
      res_d.index = idx_sum[IDX_W-1:0];
      res_d.gray  = sat_q ? GRAY_MAX : nlo_q;
    end
    if (is_report) begin
      res_d.rt_micros = cur_q.word;
    end
  end

  // Sequencer with the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // The output word is loaded when the register is free and cleared once taken.
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (head_valid_i) begin
            cur_q  <= head_i;
            prod_q <= prod_d;
            rem_q  <= numer[NUM_W-1:GRAY_W];
            nlo_q  <= numer[GRAY_W-1:0];
            sat_q  <= head_sat;
            step_q <= '0;
            state_q <= ((head_i.kind == KIND_PIXEL) && !head_sat) ? ST_DIV : ST_OUT;
          end
        end
        ST_DIV: begin
          rem_q  <= rem_nx;
          nlo_q  <= {nlo_q[GRAY_W-2:0], ge};
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(DIV_STEPS - 1)) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            res_q   <= res_d;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.result_kind     = res_q.kind;
  assign result_o.pixel_index     = res_q.index;
  assign result_o.gray_value      = res_q.gray;
  assign result_o.row_wrapped     = res_q.wrapped;
  assign result_o.pulse_seconds   = res_q.seconds;
  assign result_o.pulse_micros    = res_q.micros;
  assign result_o.scan_mode       = res_q.mode;
  assign result_o.row_time_whole  = res_q.rt_whole;
  assign result_o.row_time_micros = res_q.rt_micros;
  assign result_o.peak_level      = res_q.peak;
  assign result_o.floor_level     = res_q.trough;

endmodule

`default_nettype wire

// ===== design/scan_word_deframer_normalizer_core.sv =====
// Top level of the scan word deframer and normalizer: config registers and wiring.
// Depends on swdn_pkg, swdn_if, swdn_front, swdn_queue and swdn_back.
//
//   channel    direction  handshake      payload
//   word_i     in         valid/ready    capture_word
//   result_o   out        valid/ready    result_kind ... floor_level
//   cfg        in         cfg_we_i only  cfg_idx_i, cfg_data_i
//
// The front takes one word per cycle while the 4-entry command queue has room.
// For an unsaturated pixel the back runs setup with the row multiply, then 8
// restoring division steps, then the output load; other results skip the division.
// Words that open a line or frame record or fill any record produce no result.
// A stalled result holds in the output register; the back pops one more command and
// stops, and the queue absorbs up to four results more before word_i.ready drops.
// Reset is asynchronous and needs no clearing pass.
`default_nettype none

module scan_word_deframer_normalizer_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  swdn_word_if.sink                       word_i,
  swdn_result_if.source                   result_o,
  input  logic                            cfg_we_i,
  input  logic [swdn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [swdn_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import swdn_pkg::*;

  logic [CFG_DATA_W-1:0] line_width_q;
  logic [CFG_DATA_W-1:0] frame_height_q;
  logic                  push;
  cmd_t                  push_cmd;
  logic                  q_full;
  logic                  q_valid;
  logic                  pop;
  cmd_t                  head;

  // Configuration registers, clamped on write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= LINE_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LINE_WIDTH:   line_width_q   <= clamp_reg(cfg_data_i, LINE_WIDTH_MAX);
        REG_FRAME_HEIGHT: frame_height_q <= clamp_reg(cfg_data_i, FRAME_HEIGHT_MAX);
        default: begin
        end
      endcase
    end
  end

  swdn_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .word_i         (word_i),
    .line_width_i   (line_width_q),
    .frame_height_i (frame_height_q),
    .q_full_i       (q_full),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  swdn_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head)
  );

  swdn_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (head),
    .pop_o        (pop),
    .line_width_i (line_width_q),
    .result_o     (result_o)
  );

endmodule

`default_nettype wire

// ===== design/swdn_checker.sv =====
// Port level checks on the result channel of the deframer, bound to the top level.
// Depends on swdn_pkg and the assertion macros header.
`default_nettype none

`include "scan_word_deframer_normalizer_core_defines.svh"

module swdn_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          res_valid_i,
  input wire logic                          res_ready_i,
  input wire logic [swdn_pkg::KIND_W-1:0]   res_kind_i,
  input wire logic [swdn_pkg::IDX_W-1:0]    res_index_i,
  input wire logic [swdn_pkg::GRAY_W-1:0]   res_gray_i,
  input wire logic [swdn_pkg::WORD_W-1:0]   res_seconds_i,
  input wire logic [swdn_pkg::WORD_W-1:0]   res_micros_i,
  input wire logic [swdn_pkg::WORD_W-1:0]   res_mode_i,
  input wire logic [swdn_pkg::RTW_W-1:0]    res_rtw_i,
  input wire logic [swdn_pkg::WORD_W-1:0]   res_rtm_i,
  input wire logic [swdn_pkg::PEAK_W-1:0]   res_peak_i
);
  import swdn_pkg::*;

  // A stalled result word keeps its kind, address and gray level.
  `SWDN_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i && $stable(res_kind_i) && $stable(res_index_i) && $stable(res_gray_i))

  // Only pixels carry an address and a gray level.
  `SWDN_ASSERT_NOW(a_idx_only_pixel, res_valid_i && res_kind_i != KIND_PIXEL, res_index_i == '0 && res_gray_i == '0)

  // Once a sample has been seen the peak used for scaling is never zero.
  `SWDN_ASSERT_NOW(a_peak_set, res_valid_i && (res_kind_i == KIND_PIXEL || res_kind_i == KIND_DROP), res_peak_i != '0)

  // Status fields appear only in line and frame reports.
  `SWDN_ASSERT_NOW(a_status_only_report, res_valid_i && res_kind_i != KIND_LINE && res_kind_i != KIND_FRAME, res_seconds_i == '0 && res_micros_i == '0 && res_mode_i == '0 && res_rtw_i == '0 && res_rtm_i == '0)

endmodule

bind scan_word_deframer_normalizer_core swdn_checker u_swdn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (result_o.valid),
  .res_ready_i   (result_o.ready),
  .res_kind_i    (result_o.result_kind),
  .res_index_i   (result_o.pixel_index),
  .res_gray_i    (result_o.gray_value),
  .res_seconds_i (result_o.pulse_seconds),
  .res_micros_i  (result_o.pulse_micros),
  .res_mode_i    (result_o.scan_mode),
  .res_rtw_i     (result_o.row_time_whole),
  .res_rtm_i     (result_o.row_time_micros),
  .res_peak_i    (result_o.peak_level)
);

`default_nettype wire
